// File: rtl/cgc_pkg.sv
// Shared types, constants and constant tables for the compressor gain computer.
package cgc_pkg;

  localparam int LvlW    = 16;
  localparam int GainW   = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;
  localparam int EnvW    = 24;
  localparam int OverW   = 25;
  localparam int MulAW   = 40;
  localparam int MulBW   = 31;
  localparam int ProdW   = MulAW + MulBW;
  localparam int GW      = 31;
  localparam int ExpW    = 26;

  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ATTACK    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RELEASE   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SLOPE     = 2'd3;

  localparam logic [CfgW-1:0] THRESHOLD_RST = 16'hEC00;
  localparam logic [CfgW-1:0] ATTACK_RST    = 16'd60000;
  localparam logic [CfgW-1:0] RELEASE_RST   = 16'd65000;
  localparam logic [CfgW-1:0] SLOPE_RST     = 16'd2048;
  localparam logic [EnvW-1:0] ENV_RST       = 24'd1;

  // log2 (Q.16) to dB (Q8.8) scale, and the offset that folds the rounding
  // term and the bias of the unsigned log2 code into one constant.
  localparam logic [18:0] LOG2_DB_K  = 19'd394566;
  localparam logic [40:0] DB_OFFSET  = 41'd711645855744;
  localparam logic [22:0] OPTO_K     = 23'd4294967;
  localparam logic [21:0] DB_LOG2_K  = 22'd2786641;
  localparam logic [5:0]  EXP_IP_MAX = 6'd40;

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_LOG, S_DBMUL, S_OVER, S_ENV1, S_ENV2, S_ENV3, S_SQ,
    S_OPTO, S_RED, S_SLOPE, S_EXPM, S_EXPE, S_EXPF, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    ST_NONE, ST_LOAD, ST_NORM, ST_LOG, ST_DBMUL, ST_OVER, ST_ENV1, ST_ENV2,
    ST_ENV3, ST_SQ, ST_OPTO, ST_RED, ST_SLOPE, ST_EXPM, ST_EXPE, ST_EXPF, ST_FIN
  } step_t;

  typedef struct packed {
    step_t      step;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  typedef logic [GW-1:0] exp_tab_t [16];

  function automatic logic [63:0] isqrt_f(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = v;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Entry k is 2^-(2^-(k+1)) in Q1.30, each a square root of the one before.
  function automatic exp_tab_t exp_tab_f();
    exp_tab_t    tab;
    logic [63:0] c;
    c = isqrt_f(64'd1 << 59);
    for (int k = 0; k < 16; k++) begin
      tab[k] = c[GW-1:0];
      c      = isqrt_f(c << 30);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_f();

endpackage

// File: rtl/cgc_ctrl.sv
// Sequencer that steps the gain datapath through one item.
module cgc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cgc_pkg::sts_t sts,
  output cgc_pkg::cmd_t cmd
);
  import cgc_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_NORM;
      S_NORM:  state_nxt = S_LOG;
      S_LOG: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_DBMUL;
      end
      S_DBMUL: state_nxt = S_OVER;
      S_OVER:  state_nxt = S_ENV1;
      S_ENV1:  state_nxt = S_ENV2;
      S_ENV2:  state_nxt = S_ENV3;
      S_ENV3:  state_nxt = S_SQ;
      S_SQ:    state_nxt = S_OPTO;
      S_OPTO:  state_nxt = S_RED;
      S_RED:   state_nxt = S_SLOPE;
      S_SLOPE: state_nxt = S_EXPM;
      S_EXPM:  state_nxt = S_EXPE;
      S_EXPE:  state_nxt = S_EXPF;
      S_EXPF: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_FIN;
      end
      S_FIN:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.idx   = cnt_r;
    cmd.step  = ST_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.step = ST_LOAD;
      end
      S_NORM:  cmd.step = ST_NORM;
      S_LOG:   cmd.step = ST_LOG;
      S_DBMUL: cmd.step = ST_DBMUL;
      S_OVER:  cmd.step = ST_OVER;
      S_ENV1:  cmd.step = ST_ENV1;
      S_ENV2:  cmd.step = ST_ENV2;
      S_ENV3:  cmd.step = ST_ENV3;
      S_SQ:    cmd.step = ST_SQ;
      S_OPTO:  cmd.step = ST_OPTO;
      S_RED:   cmd.step = ST_RED;
      S_SLOPE: cmd.step = ST_SLOPE;
      S_EXPM:  cmd.step = ST_EXPM;
      S_EXPE:  cmd.step = ST_EXPE;
      S_EXPF:  cmd.step = ST_EXPF;
      S_FIN:   if (sts.out_free) cmd.step = ST_FIN;
      default: cmd.step = ST_NONE;
    endcase
  end

endmodule

// File: rtl/cgc_datapath.sv
// Datapath: settings, envelopes, one shared multiplier and the result register.
module cgc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cgc_pkg::cmd_t                 cmd,
  output cgc_pkg::sts_t                 sts,
  input  logic [cgc_pkg::LvlW-1:0]      in_level,
  input  logic                          in_sel,
  input  logic                          cfg_we,
  input  logic [cgc_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [cgc_pkg::CfgW-1:0]      cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cgc_pkg::GainW-1:0]     out_gain
);
  import cgc_pkg::*;

  logic [CfgW-1:0]  thr_r, att_r, rel_r, slope_r;
  logic [EnvW-1:0]  env_a_r, env_b_r;
  logic [LvlW-1:0]  lvl_r;
  logic             sel_r, zero_r;
  logic [15:0]      m_r, frac_r;
  logic [3:0]       p_r;
  logic [ProdW-1:0] prod_r;
  logic [OverW-1:0] over16_r;
  logic [CfgW-1:0]  coef_r;
  logic [42:0]      acc_r;
  logic [EnvW-1:0]  envn_r, red_r;
  logic [ExpW-1:0]  e_r;
  logic [GW-1:0]    g_r;
  logic [GainW-1:0] out_gain_r;
  logic             out_valid_r;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] mul_p;

  logic [3:0]       p_w;
  logic [16:0]      sq_w;
  logic [41:0]      dbsum_w;
  logic signed [17:0] db_w, over_w;
  logic [EnvW-1:0]  env_sel_w;
  logic [CfgW-1:0]  coef_w;
  logic [43:0]      envsum_w;
  logic [ProdW-1:0] curve_sum_w;
  logic [23:0]      curve_w;
  logic signed [25:0] diff_w;
  logic [ProdW-1:0] esum_w;
  logic [5:0]       s_w;
  logic [55:0]      gsh_w;

  assign env_sel_w = sel_r ? env_b_r : env_a_r;
  assign coef_w    = ({1'b0, over16_r} > {2'b0, env_sel_w}) ? att_r : rel_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      ST_LOG:   begin mul_a = MulAW'(m_r);             mul_b = MulBW'(m_r); end
      ST_DBMUL: begin mul_a = MulAW'({p_r, frac_r});   mul_b = MulBW'(LOG2_DB_K); end
      ST_ENV1:  begin mul_a = MulAW'(env_sel_w);       mul_b = MulBW'(coef_w); end
      ST_ENV2:  begin
        mul_a = MulAW'(over16_r);
        mul_b = MulBW'(17'h10000 - {1'b0, coef_r});
      end
      ST_SQ:    begin mul_a = MulAW'(envn_r);          mul_b = MulBW'(envn_r); end
      ST_OPTO:  begin mul_a = MulAW'(prod_r[47:16]);   mul_b = MulBW'(OPTO_K); end
      ST_SLOPE: begin mul_a = MulAW'(red_r);           mul_b = MulBW'(slope_r); end
      ST_EXPM:  begin mul_a = prod_r[MulAW-1:0];       mul_b = MulBW'(DB_LOG2_K); end
      ST_EXPF:  begin mul_a = MulAW'(g_r);             mul_b = EXP_TAB[cmd.idx]; end
      default:  begin mul_a = '0;                      mul_b = '0; end
    endcase
  end

  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  always_comb begin
    p_w = '0;
    for (int i = 0; i < LvlW; i++) begin
      if (lvl_r[i]) p_w = 4'(i);
    end
  end

  assign sq_w    = mul_p[31:15];
  assign dbsum_w = {1'b0, prod_r[40:0]} + {1'b0, DB_OFFSET};
  assign db_w    = zero_r ? -18'sd32768
                          : $signed({1'b0, dbsum_w[40:24]}) - 18'sd65536;
  assign over_w  = db_w - 18'(signed'(thr_r));

  assign envsum_w    = {1'b0, acc_r} + {1'b0, prod_r[42:0]} + 44'd32768;
  assign curve_sum_w = prod_r + (ProdW'(1) << 31);
  assign curve_w     = curve_sum_w[55:32];
  assign diff_w      = $signed({2'b0, envn_r}) - 26'sd1 - $signed({2'b0, curve_w});
  assign esum_w      = prod_r + (ProdW'(1) << 35);

  assign s_w   = 6'd15 + e_r[21:16];
  assign gsh_w = (56'(g_r) + (56'd1 << (s_w - 6'd1))) >> s_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RST;
      att_r       <= ATTACK_RST;
      rel_r       <= RELEASE_RST;
      slope_r     <= SLOPE_RST;
      env_a_r     <= ENV_RST;
      env_b_r     <= ENV_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_THRESHOLD: thr_r   <= cfg_wdata;
          REG_ATTACK:    att_r   <= cfg_wdata;
          REG_RELEASE:   rel_r   <= cfg_wdata;
          REG_SLOPE:     slope_r <= cfg_wdata;
          default:       ;
        endcase
      end
      if (cmd.step == ST_ENV3) begin
        if (sel_r) env_b_r <= envsum_w[39:16];
        else       env_a_r <= envsum_w[39:16];
      end
      if (cmd.step == ST_FIN)  out_valid_r <= 1'b1;
      else if (out_ready)      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      ST_LOAD: begin
        lvl_r <= in_level;
        sel_r <= in_sel;
      end
      ST_NORM: begin
        zero_r <= (lvl_r == '0);
        p_r    <= p_w;
        m_r    <= lvl_r << (4'd15 - p_w);
        frac_r <= '0;
      end
      ST_LOG: begin
        frac_r <= {frac_r[14:0], sq_w[16]};
        m_r    <= sq_w[16] ? sq_w[16:1] : sq_w[15:0];
      end
      ST_DBMUL, ST_SQ, ST_OPTO, ST_SLOPE, ST_EXPM: prod_r <= mul_p;
      ST_OVER: begin
        over16_r <= over_w[17] ? OverW'(1) : {over_w[16:0], 8'd0} + OverW'(1);
      end
      ST_ENV1: begin
        coef_r <= coef_w;
        prod_r <= mul_p;
      end
      ST_ENV2: begin
        acc_r  <= prod_r[42:0];
        prod_r <= mul_p;
      end
      ST_ENV3: envn_r <= envsum_w[39:16];
      ST_RED: begin
        if (envn_r > EnvW'(1) && !diff_w[25]) red_r <= diff_w[23:0];
        else                                  red_r <= '0;
      end
      ST_EXPE: begin
        e_r <= esum_w[61:36];
        g_r <= GW'(1) << 30;
      end
      ST_EXPF: begin
        if (e_r[4'd15 - cmd.idx]) g_r <= GW'((mul_p + (ProdW'(1) << 29)) >> 30);
      end
      ST_FIN: begin
        if (e_r[25:16] > 10'(EXP_IP_MAX)) out_gain_r <= '0;
        else if (gsh_w > 56'd65535)       out_gain_r <= '1;
        else                              out_gain_r <= gsh_w[GainW-1:0];
      end
      default: ;
    endcase
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_gain     = out_gain_r;

endmodule

// File: rtl/compressor_gain_computer_top.sv
// Top level of the feedforward log-domain compressor gain computer.
//
// Each input transfer carries a linear Q1.15 level and a detector select; the
// block answers with exactly one Q1.15 linear gain transfer. The level is
// turned into dB, the excess over the threshold is smoothed in the selected
// envelope (attack coefficient while rising, release otherwise), an opto-style
// square term is taken off, and the slope-scaled reduction is turned back into
// a linear gain no larger than 1.0. The log conversion needs 16 squaring
// steps and the exponent 16 table multiplies, all sharing a single 40x31
// multiplier, with the other steps of the item around them.
// One item is in work at a time; the input is ready again as soon as the
// result is parked in the output register, even while that result still waits
// to be taken. Configuration writes are always ready and should be made only
// while the block is idle.
module compressor_gain_computer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [15:0] level
  input  logic                        in_tuser,   // [0] detector_sel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [15:0] gain
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cgc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [cgc_pkg::CfgW-1:0]    cfg_data
);
  import cgc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Settings are plain registers, so a write is always taken.
  assign cfg_ready = 1'b1;

  cgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cgc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_level  (in_tdata),
    .in_sel    (in_tuser),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_gain  (out_tdata)
  );

endmodule

// File: rtl/cgc_checker.sv
// Port-level checks for the compressor gain computer, bound to the top level.
module cgc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A waiting result must not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The gain is never above unity.
  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 16'h8000)
    else $error("gain above unity");

  // After an input transfer the block is busy with that item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input taken while busy");

  // No result can appear in the cycle after an input transfer into an idle output.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

endmodule

bind compressor_gain_computer_top cgc_checker u_cgc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/compressor_gain_computer_top_tb.sv
// Self-checking testbench for the compressor gain computer top level.
module compressor_gain_computer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cgc_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int LatencyCycles = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_THRESHOLD;
  logic [CfgW-1:0]    cfg_data = '0;

  compressor_gain_computer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // The predictor keeps its own copy of the registers and both envelopes.
  logic signed [15:0] thr_q;
  logic [15:0] atk_q, rel_q, slope_q;
  logic [23:0] env_q [2];
  logic [15:0] gain_fifo [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int idle_cycles = 0;

  // Directed rows; a typed gain of -1 means the predictor supplies it.
  typedef struct {
    logic [15:0] level;
    logic        sel;
    int          gain;
  } vec_t;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res, bt;
    res = '0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Linear Q1.15 level to Q8.8 dB.
  function automatic int level_db(input logic [15:0] lvl);
    int p;
    logic [31:0] m;
    logic [15:0] frac;
    longint l2, v;
    if (lvl == 0) return -32768;
    p = 15;
    while (lvl[p] == 1'b0) p--;
    m = 32'(lvl) << (15 - p);
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      m = 32'((64'(m) * 64'(m)) >> 15);
      frac = frac << 1;
      if (m >= 32'd65536) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    l2 = longint'(p - 15) * 65536 + longint'(frac);
    v = l2 * 394566 + (longint'(1) << 23) + (longint'(1) << 40);
    return int'(64'(v) >> 24) - 65536;
  endfunction

  // 2^-e with e in Q.16, returned in Q1.15.
  function automatic logic [15:0] neg_exp2(input logic [63:0] e);
    logic [63:0] ip, c, g;
    int s;
    ip = e >> 16;
    if (ip > 40) return '0;
    c = root64(64'd1 << 59);
    g = 64'd1 << 30;
    for (int k = 0; k < 16; k++) begin
      if (e[15-k]) g = (g * c + (64'd1 << 29)) >> 30;
      c = root64(c << 30);
    end
    s = 15 + int'(ip);
    g = (g + (64'd1 << (s - 1))) >> s;
    if (g > 64'd65535) g = 64'd65535;
    return g[15:0];
  endfunction

  // Advances the selected envelope and returns the gain it yields.
  function automatic logic [15:0] compute_gain(input logic [15:0] lvl, input logic sel);
    int over;
    logic [63:0] over16, e_in, coef, sum, curve, red;
    longint reduced;
    over = level_db(lvl) - int'(thr_q);
    if (over < 0) over = 0;
    over16 = (64'(over) << 8) + 64'd1;
    e_in = 64'(env_q[sel]);
    coef = (over16 > e_in) ? 64'(atk_q) : 64'(rel_q);
    sum = coef * e_in + (64'd65536 - coef) * over16;
    e_in = ((sum + 64'd32768) >> 16) & 64'hFFFFFF;
    env_q[sel] = e_in[23:0];
    reduced = longint'(e_in) - 1;
    if (reduced > 0) begin
      curve = (((e_in * e_in) >> 16) * 64'd4294967 + (64'd1 << 31)) >> 32;
      reduced = reduced - longint'(curve);
      if (reduced < 0) reduced = 0;
    end else begin
      reduced = 0;
    end
    red = 64'(reduced) * 64'(slope_q);
    red = (red * 64'd2786641 + (64'd1 << 35)) >> 36;
    return neg_exp2(red);
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD: thr_q   = val;
      REG_ATTACK:    atk_q   = val;
      REG_RELEASE:   rel_q   = val;
      default:       slope_q = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every expected gain has been taken and the block is quiet.
  task automatic drain();
    while (gain_fifo.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  // Drives one transfer after a random gap; an expected gain is queued at
  // the accepting edge, before the result can possibly come back.
  task automatic send_level(input logic [15:0] lvl, input logic sel, input int typed);
    logic [15:0] g;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= lvl;
    in_tuser  <= sel;
    do @(posedge clk); while (!in_tready);
    g = compute_gain(lvl, sel);
    if (typed >= 0 && 16'(typed) != g)
      report_mismatch($sformatf("predictor gives %0d where %0d was typed", g, typed));
    gain_fifo.push_back(g);
    n_items++;
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Result side: random stalls, then one compare per accepted transfer.
  initial begin
    int stall;
    logic [15:0] want;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n_results++;
      if (gain_fifo.size() == 0) begin
        report_mismatch($sformatf("gain %0d with no expectation", out_tdata));
      end else begin
        want = gain_fifo.pop_front();
        if (out_tdata !== want)
          report_mismatch($sformatf("gain %0d, expected %0d", out_tdata, want));
      end
    end
  end

  // Watchdog: counts cycles in which no transfer happens on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d gains outstanding", gain_fifo.size());
      $display("compressor_gain_computer_top_tb: FAIL");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    vec_t rows [$];
    logic [15:0] lvl;
    thr_q = THRESHOLD_RST;
    atk_q = ATTACK_RST;
    rel_q = RELEASE_RST;
    slope_q = SLOPE_RST;
    env_q[0] = ENV_RST;
    env_q[1] = ENV_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // After reset a silent level stays below threshold: the envelope settles
    // at its floor and the gain is unity. Full scale, single-bit and alternating patterns follow.
    rows.push_back('{16'h0000, 1'b0, 32768});
    rows.push_back('{16'h0000, 1'b1, 32768});
    rows.push_back('{16'h0001, 1'b0, 32768});
    rows.push_back('{16'hFFFF, 1'b0, -1});
    rows.push_back('{16'hFFFF, 1'b0, -1});
    rows.push_back('{16'h8000, 1'b1, -1});
    rows.push_back('{16'h5555, 1'b0, -1});
    rows.push_back('{16'hAAAA, 1'b1, -1});
    rows.push_back('{16'h0000, 1'b0, -1});
    rows.push_back('{16'h0000, 1'b1, -1});
    foreach (rows[i]) send_level(rows[i].level, rows[i].sel, rows[i].gain);
    drain();

    // Extreme settings: threshold at its most negative with a steep slope and
    // instant attack, so that loud levels get a huge attenuation and a gain of 0.
    write_reg(REG_THRESHOLD, 16'h8000);
    write_reg(REG_ATTACK, 16'd0);
    write_reg(REG_RELEASE, 16'd0);
    write_reg(REG_SLOPE, 16'hFFFF);
    send_level(16'hFFFF, 1'b0, -1);
    send_level(16'h7FFF, 1'b1, -1);
    send_level(16'h0000, 1'b0, -1);
    drain();
    // Threshold patterns outside the nominal range, the other extremes.
    write_reg(REG_THRESHOLD, 16'h7FFF);
    write_reg(REG_ATTACK, 16'hFFFF);
    write_reg(REG_RELEASE, 16'hFFFF);
    write_reg(REG_SLOPE, 16'd0);
    send_level(16'hFFFF, 1'b1, -1);
    send_level(16'h0000, 1'b0, -1);
    drain();

    // Random phases with a fresh setting each; the drain between phases also
    // makes the sender wait for every outstanding gain.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_THRESHOLD, (ph == 0) ? 16'h0000 : 16'($urandom_range(0, 24576) * -1));
      write_reg(REG_ATTACK, 16'($urandom_range(0, 65535)));
      write_reg(REG_RELEASE, 16'($urandom_range(0, 65535)));
      write_reg(REG_SLOPE, (ph == 1) ? 16'hFFFF : 16'($urandom_range(0, 16384)));
      for (int i = 0; i < 62; i++) begin
        case ($urandom_range(0, 3))
          0: lvl = 16'($urandom_range(0, 65535));
          1: lvl = 16'($urandom_range(0, 65535)) >> $urandom_range(0, 15);
          2: lvl = 16'($urandom_range(0, 255));
          default: lvl = 16'hFFFF - 16'($urandom_range(0, 4095));
        endcase
        send_level(lvl, 1'($urandom_range(0, 1)), -1);
      end
      drain();
    end

    $display("Covered %0d level transfers and %0d gain transfers over", n_items, n_results);
    $display("eleven register settings, both envelopes and random stalls on each side.");
    if (errors == 0 && gain_fifo.size() == 0) begin
      $display("compressor_gain_computer_top_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d gains missing", errors, gain_fifo.size());
      $display("compressor_gain_computer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
